// File: rtl/core/pcm3m_pkg.sv
// shared types and constants for the three-source pcm mixer
package pcm3m_pkg;

	localparam int unsigned SampleW = 16;
	localparam int unsigned MaskW   = 3;
	localparam int unsigned CfgIdxW = 1;
	localparam int unsigned CfgDatW = 2;

	// configuration register indexes
	localparam logic [CfgIdxW-1:0] CfgOutFormat = 1'd0;
	localparam logic [CfgIdxW-1:0] CfgStereoOut = 1'd1;

	// output sample formats
	typedef enum logic [1:0] {
		FMT_S16 = 2'd0,
		FMT_U16 = 2'd1,
		FMT_S8  = 2'd2,
		FMT_U8  = 2'd3
	} fmt_t;

	// saturated mix of one frame
	typedef struct packed {
		logic signed [SampleW-1:0] left;
		logic signed [SampleW-1:0] right;
	} mix_t;

	// converted output pair
	typedef struct packed {
		logic [SampleW-1:0] first;
		logic [SampleW-1:0] second;
	} pair_t;

	// configuration as seen by the format converter
	typedef struct packed {
		fmt_t fmt;
		logic stereo;
	} cfg_t;

endpackage

// File: rtl/core/pcm3m_if.sv
// valid/ready channel interfaces for mixer frames and results
interface pcm3m_frame_if
	import pcm3m_pkg::*;
();
	logic                      valid;
	logic                      ready;
	logic [MaskW-1:0]          active_mask;
	logic signed [SampleW-1:0] src0_left;
	logic signed [SampleW-1:0] src0_right;
	logic signed [SampleW-1:0] src1_left;
	logic signed [SampleW-1:0] src1_right;
	logic signed [SampleW-1:0] src2_left;
	logic signed [SampleW-1:0] src2_right;

	modport source (
		output valid, active_mask, src0_left, src0_right,
		       src1_left, src1_right, src2_left, src2_right,
		input  ready
	);
	modport sink (
		input  valid, active_mask, src0_left, src0_right,
		       src1_left, src1_right, src2_left, src2_right,
		output ready
	);
endinterface

interface pcm3m_result_if
	import pcm3m_pkg::*;
();
	logic               valid;
	logic               ready;
	logic [SampleW-1:0] out_first;
	logic [SampleW-1:0] out_second;

	modport source (output valid, out_first, out_second, input ready);
	modport sink (input valid, out_first, out_second, output ready);
endinterface

// File: rtl/core/pcm_three_source_mixer_top.sv
// top level: input register, mix and convert, result register
// path: an accepted request is held in the input register, then in the result register, where its result shows
// throughput: one frame per cycle while the result side is ready; the two registers form a stalling pipeline
// a stall on the result side holds that stage; ready drops once the input stage is also full
// reset: asynchronous, active low; empties the pipeline, format signed 16, stereo on
module pcm_three_source_mixer_top
	import pcm3m_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [CfgIdxW-1:0] cfg_index,
	input  logic [CfgDatW-1:0] cfg_data,
	pcm3m_frame_if.sink        frame,
	pcm3m_result_if.source     result
);

	cfg_t                      cfg_q;
	logic                      v_s1;
	logic                      v_s2;
	logic                      adv_s1;
	logic                      adv_s2;
	logic [MaskW-1:0]          mask_s1;
	logic signed [SampleW-1:0] s0_l_s1;
	logic signed [SampleW-1:0] s0_r_s1;
	logic signed [SampleW-1:0] s1_l_s1;
	logic signed [SampleW-1:0] s1_r_s1;
	logic signed [SampleW-1:0] s2_l_s1;
	logic signed [SampleW-1:0] s2_r_s1;
	mix_t                      mix;
	pair_t                     conv;
	pair_t                     res_s2;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.fmt    <= FMT_S16;
			cfg_q.stereo <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				CfgOutFormat: cfg_q.fmt    <= fmt_t'(cfg_data);
				CfgStereoOut: cfg_q.stereo <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// stage advance: a stage moves when the one after it is free
	assign adv_s2      = !v_s2 || result.ready;
	assign adv_s1      = !v_s1 || adv_s2;
	assign frame.ready = adv_s1;

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (adv_s1)
				v_s1 <= frame.valid;
			if (adv_s2)
				v_s2 <= v_s1;
		end
	end

	// input register
	always_ff @(posedge clk) begin
		if (adv_s1 && frame.valid) begin
			mask_s1 <= frame.active_mask;
			s0_l_s1 <= frame.src0_left;
			s0_r_s1 <= frame.src0_right;
			s1_l_s1 <= frame.src1_left;
			s1_r_s1 <= frame.src1_right;
			s2_l_s1 <= frame.src2_left;
			s2_r_s1 <= frame.src2_right;
		end
	end

	pcm3m_mix u_mix (
		.mask (mask_s1),
		.s0_l (s0_l_s1),
		.s0_r (s0_r_s1),
		.s1_l (s1_l_s1),
		.s1_r (s1_r_s1),
		.s2_l (s2_l_s1),
		.s2_r (s2_r_s1),
		.mix  (mix)
	);

	pcm3m_conv u_conv (
		.mix (mix),
		.cfg (cfg_q),
		.res (conv)
	);

	// result register
	always_ff @(posedge clk) begin
		if (adv_s2 && v_s1)
			res_s2 <= conv;
	end

	assign result.valid      = v_s2;
	assign result.out_first  = res_s2.first;
	assign result.out_second = res_s2.second;

	// an accepted request always lands in the input stage
	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		frame.valid && frame.ready |=> v_s1)
		else $error("accepted request lost before input stage");

	// a moving input stage always fills the result stage
	a_s1_moves_to_s2: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && adv_s2 |=> v_s2)
		else $error("input stage advanced without filling result stage");

	// an empty pipeline never refuses a request
	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s1 && !v_s2 |-> frame.ready)
		else $error("empty pipeline not ready");

	// a stalled result stays put
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && !result.ready |=> v_s2 && $stable(res_s2))
		else $error("stalled result changed");

endmodule

// File: rtl/core/pcm3m_mix.sv
// masked three-source sum with saturation to signed 16 bits
module pcm3m_mix
	import pcm3m_pkg::*;
(
	input  logic [MaskW-1:0]          mask,
	input  logic signed [SampleW-1:0] s0_l,
	input  logic signed [SampleW-1:0] s0_r,
	input  logic signed [SampleW-1:0] s1_l,
	input  logic signed [SampleW-1:0] s1_r,
	input  logic signed [SampleW-1:0] s2_l,
	input  logic signed [SampleW-1:0] s2_r,
	output mix_t                      mix
);

	localparam int unsigned SumW = SampleW + 2;
	localparam logic signed [SumW-1:0] MaxS = SumW'(32767);
	localparam logic signed [SumW-1:0] MinS = -SumW'(32768);

	logic signed [SumW-1:0] sum_l;
	logic signed [SumW-1:0] sum_r;

	// gated sums, three terms fit in two guard bits
	always_comb begin
		sum_l = (mask[0] ? SumW'(s0_l) : '0)
		      + (mask[1] ? SumW'(s1_l) : '0)
		      + (mask[2] ? SumW'(s2_l) : '0);
		sum_r = (mask[0] ? SumW'(s0_r) : '0)
		      + (mask[1] ? SumW'(s1_r) : '0)
		      + (mask[2] ? SumW'(s2_r) : '0);
	end

	// clamp once after the sum
	always_comb begin
		if (sum_l > MaxS)
			mix.left = MaxS[SampleW-1:0];
		else if (sum_l < MinS)
			mix.left = MinS[SampleW-1:0];
		else
			mix.left = sum_l[SampleW-1:0];
		if (sum_r > MaxS)
			mix.right = MaxS[SampleW-1:0];
		else if (sum_r < MinS)
			mix.right = MinS[SampleW-1:0];
		else
			mix.right = sum_r[SampleW-1:0];
	end

endmodule

// File: rtl/core/pcm3m_conv.sv
// output format conversion and mono downmix
module pcm3m_conv
	import pcm3m_pkg::*;
(
	input  mix_t  mix,
	input  cfg_t  cfg,
	output pair_t res
);

	logic signed [SampleW:0] mono;

	// mono sum, one bit wider than a sample
	assign mono = {mix.left[SampleW-1], mix.left} + {mix.right[SampleW-1], mix.right};

	// format selection; unsigned forms flip the sign bit
	always_comb begin
		res = '0;
		if (cfg.stereo) begin
			case (cfg.fmt)
				FMT_S16: begin
					res.first  = mix.left;
					res.second = mix.right;
				end
				FMT_U16: begin
					res.first  = {~mix.left[SampleW-1], mix.left[SampleW-2:0]};
					res.second = {~mix.right[SampleW-1], mix.right[SampleW-2:0]};
				end
				FMT_S8: begin
					res.first  = {8'd0, mix.left[SampleW-1:8]};
					res.second = {8'd0, mix.right[SampleW-1:8]};
				end
				FMT_U8: begin
					res.first  = {8'd0, ~mix.left[SampleW-1], mix.left[SampleW-2:8]};
					res.second = {8'd0, ~mix.right[SampleW-1], mix.right[SampleW-2:8]};
				end
				default: res = '0;
			endcase
		end else begin
			case (cfg.fmt)
				FMT_S16: res.first = mono[SampleW:1];
				FMT_U16: res.first = {~mono[SampleW], mono[SampleW-1:1]};
				FMT_S8:  res.first = {8'd0, mono[SampleW:9]};
				FMT_U8:  res.first = {8'd0, ~mono[SampleW], mono[SampleW-1:9]};
				default: res.first = '0;
			endcase
		end
	end

endmodule
